[hdl/tgarle_pkg.sv]
// ---------------------------------------------------------------------------
// tgarle_pkg: shared types and constants
// Widths, register indexes and control types of the RLE pixel decoder.
// ---------------------------------------------------------------------------
package tgarle_pkg;

   localparam int BYTE_WIDTH   = 8;
   localparam int DIM_WIDTH    = 16;
   localparam int PIXEL_WIDTH  = 2 * DIM_WIDTH;
   localparam int CSR_IDX_WIDTH = 1;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [BYTE_WIDTH-1:0] RUN_BIAS = 8'd127;

   localparam logic [1:0] SLOT_BLUE  = 2'd0;
   localparam logic [1:0] SLOT_GREEN = 2'd1;
   localparam logic [1:0] SLOT_RED   = 2'd2;

   // size unit -> decode core
   typedef struct packed {
      logic                   restart;  // clear decode state
      logic                   empty;    // width or height is zero
      logic                   load;     // take pixel total
      logic [PIXEL_WIDTH-1:0] total;    // width * height
   } size_ctl_type;

endpackage

[hdl/tgarle_req_if.sv]
// ---------------------------------------------------------------------------
// tgarle_req_if: compressed byte channel
// Valid/ready channel carrying one stream byte per transaction.
// ---------------------------------------------------------------------------
interface tgarle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

[hdl/tgarle_rsp_if.sv]
// ---------------------------------------------------------------------------
// tgarle_rsp_if: decoded pixel channel
// Valid/ready channel carrying one pixel or run per transaction.
// ---------------------------------------------------------------------------
interface tgarle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] blue;
   logic [7:0] green;
   logic [7:0] red;
   logic [7:0] repeat_count;
   logic       image_end;

   modport source (output valid, output blue, output green, output red,
                   output repeat_count, output image_end, input ready);
   modport sink   (input valid, input blue, input green, input red,
                   input repeat_count, input image_end, output ready);
endinterface

[hdl/tgarle_size.sv]
// ---------------------------------------------------------------------------
// tgarle_size: image size registers
// Holds width and height, forms the pixel total and sequences a restart.
// ---------------------------------------------------------------------------
module tgarle_size (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [tgarle_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [tgarle_pkg::DIM_WIDTH-1:0]     csr_wdata,
   output tgarle_pkg::size_ctl_type             size_ctl
);
   import tgarle_pkg::*;

   logic [DIM_WIDTH-1:0]   width_ff, width_in;
   logic [DIM_WIDTH-1:0]   height_ff, height_in;
   logic [PIXEL_WIDTH-1:0] total_ff, total_in;
   logic [1:0]             seq_ff, seq_in;
   logic                   hit;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      hit       = 1'b0;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_in = csr_wdata;
               hit      = 1'b1;
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = csr_wdata;
               hit       = 1'b1;
            end
            default: hit = 1'b0;
         endcase
      end
      // restart in the cycle after the write, total loaded in the cycle after that
      seq_in   = {seq_ff[0], hit};
      total_in = PIXEL_WIDTH'(width_ff) * PIXEL_WIDTH'(height_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_WIDTH'(1);
         height_ff <= DIM_WIDTH'(1);
         seq_ff    <= 2'b00;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         seq_ff    <= seq_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
   end

   assign size_ctl.restart = seq_ff[0];
   assign size_ctl.load    = seq_ff[1];
   assign size_ctl.empty   = (width_ff == '0) || (height_ff == '0);
   assign size_ctl.total   = total_ff;

endmodule

[hdl/tgarle_core.sv]
// ---------------------------------------------------------------------------
// tgarle_core: packet decode datapath
// Input byte register, packet/colour state and the result register.
// ---------------------------------------------------------------------------
module tgarle_core (
   input  logic                     clock,
   input  logic                     reset,
   input  tgarle_pkg::size_ctl_type size_ctl,
   tgarle_req_if.sink               req_chan,
   tgarle_rsp_if.source             rsp_chan
);
   import tgarle_pkg::*;

   // input register
   logic                  byte_vld_ff, byte_vld_in;
   logic [BYTE_WIDTH-1:0] byte_ff, byte_in;
   // decode state
   logic                   expect_hdr_ff, expect_hdr_in;
   logic                   run_ff, run_in;
   logic [BYTE_WIDTH-1:0]  in_packet_ff, in_packet_in;
   logic [1:0]             slot_ff, slot_in;
   logic [BYTE_WIDTH-1:0]  blue_ff, blue_in;
   logic [BYTE_WIDTH-1:0]  green_ff, green_in;
   logic [PIXEL_WIDTH-1:0] remaining_ff, remaining_in;
   logic                   finished_ff, finished_in;
   // result register
   logic                  out_vld_ff, out_vld_in;
   logic [BYTE_WIDTH-1:0] out_blue_ff, out_blue_in;
   logic [BYTE_WIDTH-1:0] out_green_ff, out_green_in;
   logic [BYTE_WIDTH-1:0] out_red_ff, out_red_in;
   logic [BYTE_WIDTH-1:0] out_count_ff, out_count_in;
   logic                  out_end_ff, out_end_in;

   logic                   advance;
   logic                   step;
   logic [BYTE_WIDTH-1:0]  count;
   logic [BYTE_WIDTH-1:0]  left;
   logic [PIXEL_WIDTH-1:0] remaining_dec;

   assign advance        = !out_vld_ff || rsp_chan.ready;
   assign step           = byte_vld_ff && advance;
   assign req_chan.ready = !byte_vld_ff || advance;

   always_comb begin
      byte_vld_in = byte_vld_ff;
      byte_in     = byte_ff;
      if (step) begin
         byte_vld_in = 1'b0;
      end
      if (req_chan.valid && req_chan.ready) begin
         byte_vld_in = 1'b1;
         byte_in     = req_chan.data_byte;
      end
   end

   always_comb begin
      expect_hdr_in = expect_hdr_ff;
      run_in        = run_ff;
      in_packet_in  = in_packet_ff;
      slot_in       = slot_ff;
      blue_in       = blue_ff;
      green_in      = green_ff;
      remaining_in  = remaining_ff;
      finished_in   = finished_ff;
      out_vld_in    = out_vld_ff && !rsp_chan.ready;
      out_blue_in   = out_blue_ff;
      out_green_in  = out_green_ff;
      out_red_in    = out_red_ff;
      out_count_in  = out_count_ff;
      out_end_in    = out_end_ff;
      count         = run_ff ? in_packet_ff : BYTE_WIDTH'(1);
      left          = run_ff ? '0 : in_packet_ff - BYTE_WIDTH'(1);
      // clip the run to the pixels still missing
      if (remaining_ff[PIXEL_WIDTH-1:BYTE_WIDTH] == '0
          && remaining_ff[BYTE_WIDTH-1:0] < count) begin
         count = remaining_ff[BYTE_WIDTH-1:0];
      end
      remaining_dec = remaining_ff - PIXEL_WIDTH'(count);

      if (size_ctl.restart) begin
         expect_hdr_in = 1'b1;
         run_in        = 1'b0;
         in_packet_in  = '0;
         slot_in       = SLOT_BLUE;
         blue_in       = '0;
         green_in      = '0;
         finished_in   = size_ctl.empty;
      end else if (step && !finished_ff) begin
         if (expect_hdr_ff) begin
            run_in        = byte_ff[BYTE_WIDTH-1];
            in_packet_in  = byte_ff[BYTE_WIDTH-1] ? byte_ff - RUN_BIAS
                                                  : byte_ff + BYTE_WIDTH'(1);
            slot_in       = SLOT_BLUE;
            expect_hdr_in = 1'b0;
         end else begin
            unique case (slot_ff)
               SLOT_BLUE: begin
                  blue_in = byte_ff;
                  slot_in = SLOT_GREEN;
               end
               SLOT_GREEN: begin
                  green_in = byte_ff;
                  slot_in  = SLOT_RED;
               end
               default: begin
                  slot_in       = SLOT_BLUE;
                  in_packet_in  = left;
                  expect_hdr_in = (left == '0);
                  remaining_in  = remaining_dec;
                  finished_in   = (remaining_dec == '0);
                  out_vld_in    = 1'b1;
                  out_blue_in   = blue_ff;
                  out_green_in  = green_ff;
                  out_red_in    = byte_ff;
                  out_count_in  = count;
                  out_end_in    = (remaining_dec == '0);
               end
            endcase
         end
      end

      if (size_ctl.load) begin
         remaining_in = size_ctl.total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_vld_ff   <= 1'b0;
         expect_hdr_ff <= 1'b1;
         run_ff        <= 1'b0;
         in_packet_ff  <= '0;
         slot_ff       <= SLOT_BLUE;
         blue_ff       <= '0;
         green_ff      <= '0;
         remaining_ff  <= PIXEL_WIDTH'(1);
         finished_ff   <= 1'b0;
         out_vld_ff    <= 1'b0;
      end else begin
         byte_vld_ff   <= byte_vld_in;
         expect_hdr_ff <= expect_hdr_in;
         run_ff        <= run_in;
         in_packet_ff  <= in_packet_in;
         slot_ff       <= slot_in;
         blue_ff       <= blue_in;
         green_ff      <= green_in;
         remaining_ff  <= remaining_in;
         finished_ff   <= finished_in;
         out_vld_ff    <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      out_blue_ff  <= out_blue_in;
      out_green_ff <= out_green_in;
      out_red_ff   <= out_red_in;
      out_count_ff <= out_count_in;
      out_end_ff   <= out_end_in;
   end

   assign rsp_chan.valid        = out_vld_ff;
   assign rsp_chan.blue         = out_blue_ff;
   assign rsp_chan.green        = out_green_ff;
   assign rsp_chan.red          = out_red_ff;
   assign rsp_chan.repeat_count = out_count_ff;
   assign rsp_chan.image_end    = out_end_ff;

endmodule

[hdl/tga_rle_pixel_decoder.sv]
// ---------------------------------------------------------------------------
// tga_rle_pixel_decoder: 24-bit run-length image stream decoder
// Turns a byte stream of run and raw packets into pixels with repeat counts.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one compressed byte per transaction (header or colour
//   byte in blue, green, red order). rsp_chan carries one result per run
//   packet or per raw pixel: colour, repeat count (clipped at image end) and
//   an image_end flag on the result that completes width*height pixels.
//   Header and blue/green bytes give no result; bytes after image end are
//   dropped until a restart.
//   csr_write_en/csr_index/csr_wdata set image width (index 0) and height
//   (index 1); each write restarts decoding. Write only while idle.
// Timing:
//   One byte per cycle sustained while rsp_chan is not stalled. A byte passes
//   the input register and one decode step, so a red byte's result is
//   registered in the result register. The pixel total is formed by one 16x16
//   multiply of the width and height registers into a total register.
// Reset: size 1x1, decoder waits for a header. If rsp_chan stalls, a byte is
//   still taken while the input register is empty, then req_chan.ready drops.
// ---------------------------------------------------------------------------
module tga_rle_pixel_decoder (
   input  logic                                 clock,
   input  logic                                 reset,
   tgarle_req_if.sink                           req_chan,
   tgarle_rsp_if.source                         rsp_chan,
   input  logic                                 csr_write_en,
   input  logic [tgarle_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [tgarle_pkg::DIM_WIDTH-1:0]     csr_wdata
);
   import tgarle_pkg::*;

   size_ctl_type size_ctl;

   tgarle_size u_size (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .size_ctl     (size_ctl)
   );

   tgarle_core u_core (
      .clock    (clock),
      .reset    (reset),
      .size_ctl (size_ctl),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

[hdl/tgarle_checker.sv]
// ---------------------------------------------------------------------------
// tgarle_checker: port-level assertions
// Checks result channel behavior of the decoder as seen on its ports.
// ---------------------------------------------------------------------------
module tgarle_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_repeat_count,
   input logic       rsp_image_end
);
   import tgarle_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_repeat_count))
      else $error("result dropped or changed while stalled");

   // input only backs up when the result side is stalled
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output backpressure");

   // a run never carries more than 128 pixels and never zero
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_repeat_count != 8'd0 && rsp_repeat_count <= 8'd128)
      else $error("repeat count out of range");

   // nothing follows the last pixel right away
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_image_end |=> !rsp_valid)
      else $error("result after image end");

endmodule

bind tga_rle_pixel_decoder tgarle_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_repeat_count (rsp_chan.repeat_count),
   .rsp_image_end    (rsp_chan.image_end)
);

[test/testbench.sv]
// ---------------------------------------------------------------------------
// testbench: RLE pixel decoder regression
// Drives compressed byte streams (run and raw packets, noise, trailing bytes)
// into tga_rle_pixel_decoder under random idling and a long output stall,
// and checks every decoded pixel against a cycle-free decode model.
// ---------------------------------------------------------------------------
module testbench;
   import tgarle_pkg::*;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] repeat_count;
      logic       image_end;
   } pixel_type;

   typedef enum logic {ROW_BYTE, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type             kind;
      logic [CSR_IDX_WIDTH-1:0] index;
      logic [DIM_WIDTH-1:0]     value;
      logic                     has_want;
      pixel_type                want;
   } row_type;

   localparam int RANDOM_ITEMS = 2000;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_write_en;
   logic [CSR_IDX_WIDTH-1:0] csr_index;
   logic [DIM_WIDTH-1:0]     csr_wdata;

   tgarle_req_if req_bus ();
   tgarle_rsp_if rsp_bus ();

   tga_rle_pixel_decoder DUT (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_bus),
      .rsp_chan     (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

   // ---- decode model state ----
   logic [DIM_WIDTH-1:0] width_reg;
   logic [DIM_WIDTH-1:0] height_reg;
   logic                 await_header;
   logic                 in_run;
   logic [7:0]           packet_left;
   logic [1:0]           color_idx;
   logic [7:0]           hold_blue;
   logic [7:0]           hold_green;
   logic [31:0]          pixels_left;
   logic                 image_done;

   pixel_type pixel_queue[$];
   int        error_count = 0;
   int        live_items  = 0;
   int        stall_left  = 0;
   logic      idle_on;
   logic      hold_rsp;
   row_type   directed_rows[];

   task automatic flag_error(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic void restart_decode();
      await_header = 1'b1;
      in_run       = 1'b0;
      packet_left  = '0;
      color_idx    = SLOT_BLUE;
      hold_blue    = '0;
      hold_green   = '0;
      pixels_left  = width_reg * height_reg;
      image_done   = (pixels_left == 0);
   endfunction

   // Returns 1 when the byte completes a pixel or run.
   function automatic logic decode_byte(input logic [7:0] b, output pixel_type px);
      logic [31:0] cnt;
      px = '0;
      if (image_done)
         return 1'b0;
      if (await_header) begin
         if (b > RUN_BIAS) begin
            in_run      = 1'b1;
            packet_left = b - RUN_BIAS;
         end else begin
            in_run      = 1'b0;
            packet_left = b + 8'd1;
         end
         color_idx    = SLOT_BLUE;
         await_header = 1'b0;
         return 1'b0;
      end
      if (color_idx == SLOT_BLUE) begin
         hold_blue = b;
         color_idx = SLOT_GREEN;
         return 1'b0;
      end
      if (color_idx == SLOT_GREEN) begin
         hold_green = b;
         color_idx  = SLOT_RED;
         return 1'b0;
      end
      color_idx = SLOT_BLUE;
      if (in_run) begin
         cnt         = 32'(packet_left);
         packet_left = '0;
      end else begin
         cnt         = 32'd1;
         packet_left = packet_left - 8'd1;
      end
      if (packet_left == 0)
         await_header = 1'b1;
      if (cnt > pixels_left)
         cnt = pixels_left;
      pixels_left = pixels_left - cnt;
      if (pixels_left == 0)
         image_done = 1'b1;
      px = '{hold_blue, hold_green, b, cnt[7:0], image_done};
      return 1'b1;
   endfunction

   // ---- result side ----
   task automatic compare_field(input string name, input logic [7:0] got,
                                input logic [7:0] want);
      if (got !== want)
         flag_error($sformatf("%s mismatch: got %0h want %0h", name, got, want));
   endtask

   task automatic check_pixel();
      pixel_type want;
      if (pixel_queue.size() == 0) begin
         flag_error($sformatf("unexpected pixel %h %h %h x%0d end=%b",
                    rsp_bus.blue, rsp_bus.green, rsp_bus.red,
                    rsp_bus.repeat_count, rsp_bus.image_end));
         return;
      end
      want = pixel_queue.pop_front();
      compare_field("blue", rsp_bus.blue, want.blue);
      compare_field("green", rsp_bus.green, want.green);
      compare_field("red", rsp_bus.red, want.red);
      compare_field("repeat_count", rsp_bus.repeat_count, want.repeat_count);
      compare_field("image_end", 8'(rsp_bus.image_end), 8'(want.image_end));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         check_pixel();
      if (hold_rsp) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left = $urandom_range(0, 3);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // ---- stimulus side ----
   task automatic push_byte(input logic [7:0] b, input logic use_want,
                            input pixel_type want);
      pixel_type px;
      logic      made;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      if (!image_done)
         live_items++;
      made = decode_byte(b, px);
      if (made)
         pixel_queue.push_back(use_want ? want : px);
   endtask

   task automatic push_random(input int count);
      repeat (count) push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
   endtask

   // Quiet the input and let in-flight bytes drain before a size write.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_size(input logic [CSR_IDX_WIDTH-1:0] idx,
                             input logic [DIM_WIDTH-1:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH)
         width_reg = val;
      else
         height_reg = val;
      restart_decode();
      // wait for the pixel total to settle after the write
      repeat (4) @(posedge clock);
   endtask

   // Mostly well-formed packets with random content, some stray bytes.
   task automatic run_image(input logic [DIM_WIDTH-1:0] w,
                            input logic [DIM_WIDTH-1:0] h, input int budget);
      logic [7:0] hdr;
      int         start;
      settle();
      if (w != width_reg || $urandom_range(0, 1) == 0)
         write_size(CSR_IMAGE_WIDTH, w);
      write_size(CSR_IMAGE_HEIGHT, h);
      start = live_items;
      while (!image_done && live_items - start < budget) begin
         if ($urandom_range(0, 9) == 0) begin
            push_random($urandom_range(1, 5));
         end else begin
            hdr = 8'($urandom_range(0, 255));
            push_byte(hdr, 1'b0, '0);
            if (hdr > RUN_BIAS)
               push_random(3);
            else
               for (int p = 0; p <= hdr && !image_done; p++)
                  push_random(3);
         end
      end
      if (image_done)
         push_random($urandom_range(1, 3));
   endtask

   function automatic row_type data_row(input logic [7:0] b);
      return '{ROW_BYTE, '0, {8'h00, b}, 1'b0, '0};
   endfunction

   function automatic row_type pixel_row(input logic [7:0] b, input pixel_type want);
      return '{ROW_BYTE, '0, {8'h00, b}, 1'b1, want};
   endfunction

   function automatic row_type size_row(input logic [CSR_IDX_WIDTH-1:0] idx,
                                        input logic [DIM_WIDTH-1:0] val);
      return '{ROW_CSR, idx, val, 1'b0, '0};
   endfunction

   initial begin
      int waited;
      logic [DIM_WIDTH-1:0] w;
      logic [DIM_WIDTH-1:0] h;
      int pick;

      reset             = 1'b1;
      csr_write_en      = 1'b0;
      csr_index         = CSR_IMAGE_WIDTH;
      csr_wdata         = '0;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      rsp_bus.ready     = 1'b0;
      idle_on           = 1'b1;
      hold_rsp          = 1'b0;
      width_reg         = 16'd1;
      height_reg        = 16'd1;
      restart_decode();

      directed_rows = '{
         // 1x1 after reset: a run of one ends the image, then bytes are dropped
         data_row(8'h80), data_row(8'h00), data_row(8'hFF),
         pixel_row(8'h12, '{8'h00, 8'hFF, 8'h12, 8'd1, 1'b1}),
         data_row(8'h55),
         // longest run clipped to a 3x2 image
         size_row(CSR_IMAGE_WIDTH, 16'd3), size_row(CSR_IMAGE_HEIGHT, 16'd2),
         data_row(8'hFF), data_row(8'hFF), data_row(8'hFF),
         pixel_row(8'hFF, '{8'hFF, 8'hFF, 8'hFF, 8'd6, 1'b1}),
         // largest image, longest raw packet
         size_row(CSR_IMAGE_WIDTH, 16'hFFFF), size_row(CSR_IMAGE_HEIGHT, 16'hFFFF),
         data_row(8'h7F), data_row(8'h01), data_row(8'h02),
         pixel_row(8'h03, '{8'h01, 8'h02, 8'h03, 8'd1, 1'b0}),
         data_row(8'hA5), data_row(8'h5A),
         pixel_row(8'hC3, '{8'hA5, 8'h5A, 8'hC3, 8'd1, 1'b0}),
         // zero height: everything ignored
         size_row(CSR_IMAGE_HEIGHT, 16'd0),
         data_row(8'h80), data_row(8'h11),
         // 1x2: single raw pixel, then a run of two clipped to one
         size_row(CSR_IMAGE_WIDTH, 16'd1), size_row(CSR_IMAGE_HEIGHT, 16'd2),
         data_row(8'h00), data_row(8'h10), data_row(8'h20),
         pixel_row(8'h30, '{8'h10, 8'h20, 8'h30, 8'd1, 1'b0}),
         data_row(8'h81), data_row(8'h40), data_row(8'h50),
         pixel_row(8'h60, '{8'h40, 8'h50, 8'h60, 8'd1, 1'b1})
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            settle();
            write_size(directed_rows[i].index, directed_rows[i].value);
         end else begin
            push_byte(directed_rows[i].value[7:0], directed_rows[i].has_want,
                      directed_rows[i].want);
         end
      end

      // output held off while the input keeps offering bytes
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (300) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         run_image(16'd64, 16'd64, 150);
      join

      waited = live_items;
      while (live_items - waited < RANDOM_ITEMS) begin
         if (live_items - waited > RANDOM_ITEMS - 300)
            idle_on <= 1'b0;
         pick = $urandom_range(0, 19);
         if (pick < 14) begin
            w = 16'($urandom_range(1, 12));
            h = 16'($urandom_range(1, 12));
         end else if (pick < 16) begin
            w = 16'd1;
            h = 16'($urandom_range(1, 40));
         end else if (pick < 17) begin
            w = 16'($urandom_range(1, 40));
            h = 16'd1;
         end else if (pick < 19) begin
            w = 16'hFFFF;
            h = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'd1;
         end else begin
            w = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'd5;
            h = (w == 0) ? 16'd7 : 16'd0;
         end
         run_image(w, h, 200);
      end

      req_bus.valid <= 1'b0;
      waited = 0;
      while (pixel_queue.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (pixel_queue.size() != 0)
         flag_error($sformatf("%0d expected pixels never arrived", pixel_queue.size()));

      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
